// ===== rtl/core/dsnp_pkg.sv =====
// dsnp_pkg: shared types and constants of the dma register snoop block
// payload structs, configuration struct, register map and fifo sizing
// no dependencies
package dsnp_pkg;

	localparam logic [23:0] REG_SPAN_LOW  = 24'hFF8600;
	localparam logic [23:0] REG_SPAN_HIGH = 24'hFF860F;
	localparam logic [23:0] DATA_REG_ODD  = 24'hFF8605;
	localparam logic [23:0] MODE_REG_ODD  = 24'hFF8607;
	localparam logic [23:0] DATA_REG      = 24'hFF8604;
	localparam logic [23:0] MODE_REG      = 24'hFF8606;
	localparam logic [23:0] BASE_HIGH_REG = 24'hFF8609;
	localparam logic [23:0] BASE_MID_REG  = 24'hFF860B;
	localparam logic [23:0] BASE_LOW_REG  = 24'hFF860D;

	localparam int SECTOR_SHIFT = 9;

	localparam logic [24:0] RAM_LIMIT_RESET   = 25'h0400000;
	localparam logic [15:0] COUNT_SEL_RESET   = 16'h0010;
	localparam logic [15:0] DIRECTION_RESET   = 16'h0100;
	localparam logic [15:0] COUNT_ZERO_RESET  = 16'h0002;

	localparam int PADDR_W = 5;

	localparam logic [2:0] IDX_SNOOP_ENABLE = 3'd0;
	localparam logic [2:0] IDX_RAM_LIMIT    = 3'd1;
	localparam logic [2:0] IDX_COUNT_SEL    = 3'd2;
	localparam logic [2:0] IDX_DIRECTION    = 3'd3;
	localparam logic [2:0] IDX_COUNT_ZERO   = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic DIR_PULL = 1'b0;
	localparam logic DIR_PUSH = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic        operation;
		logic [23:0] bus_address;
		logic [15:0] bus_data;
	} access_t;

	typedef struct packed {
		logic        sync_direction;
		logic [23:0] sync_base;
		logic [7:0]  sync_sectors;
	} sync_cmd_t;

	typedef struct packed {
		logic        snoop_enable;
		logic [24:0] ram_limit;
		logic [15:0] count_select_mask;
		logic [15:0] direction_mask;
		logic [15:0] count_zero_mask;
	} cfg_t;

endpackage

// ===== rtl/core/dsnp_front.sv =====
// dsnp_front: accepts bus accesses, tracks the controller shadows and the window
// emits candidate sync commands into the queue; uses dsnp_pkg
module dsnp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  dsnp_pkg::cfg_t     cfg,
	input  logic               accept,
	input  dsnp_pkg::access_t  access,
	output logic               push,
	output dsnp_pkg::sync_cmd_t push_cmd
);
	import dsnp_pkg::*;

	logic [23:0] base_shadow_q;
	logic [15:0] mode_shadow_q;
	logic [7:0]  count_shadow_q;
	logic [23:0] window_base_q;
	logic [7:0]  window_sectors_q;
	logic        window_to_device_q;
	logic        window_armed_q;

	logic [23:0] addr_f;
	logic        hit_done;
	logic        count_sel;
	logic        do_arm;
	logic        arm_push;

	always_comb begin
		addr_f = access.bus_address;
		if (access.bus_address == DATA_REG_ODD || access.bus_address == MODE_REG_ODD) begin
			addr_f = {access.bus_address[23:1], 1'b0};
		end
	end

	assign hit_done  = accept && cfg.snoop_enable && access.operation == OP_READ
		&& window_armed_q && addr_f == MODE_REG
		&& ((access.bus_data & cfg.count_zero_mask) != 16'd0);
	assign count_sel = (mode_shadow_q & cfg.count_select_mask) != 16'd0;
	assign do_arm    = accept && cfg.snoop_enable && access.operation == OP_WRITE
		&& addr_f == DATA_REG && !count_sel && count_shadow_q != 8'd0;
	assign arm_push  = (mode_shadow_q & cfg.direction_mask) != 16'd0;

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		if (do_arm && arm_push) begin
			push                    = 1'b1;
			push_cmd.sync_direction = DIR_PUSH;
			push_cmd.sync_base      = base_shadow_q;
			push_cmd.sync_sectors   = count_shadow_q;
		end else if (hit_done && !window_to_device_q) begin
			push                    = 1'b1;
			push_cmd.sync_direction = DIR_PULL;
			push_cmd.sync_base      = window_base_q;
			push_cmd.sync_sectors   = window_sectors_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_shadow_q      <= '0;
			mode_shadow_q      <= '0;
			count_shadow_q     <= '0;
			window_base_q      <= '0;
			window_sectors_q   <= '0;
			window_to_device_q <= 1'b0;
			window_armed_q     <= 1'b0;
		end else if (accept && cfg.snoop_enable) begin
			if (access.operation == OP_READ) begin
				if (hit_done) begin
					window_armed_q <= 1'b0;
					count_shadow_q <= '0;
				end
			end else begin
				case (addr_f)
					BASE_HIGH_REG: base_shadow_q[23:16] <= access.bus_data[7:0];
					BASE_MID_REG:  base_shadow_q[15:8]  <= access.bus_data[7:0];
					BASE_LOW_REG:  base_shadow_q[7:0]   <= access.bus_data[7:0];
					MODE_REG:      mode_shadow_q        <= access.bus_data;
					DATA_REG: begin
						if (count_sel) begin
							count_shadow_q <= access.bus_data[7:0];
						end else if (do_arm) begin
							window_base_q      <= base_shadow_q;
							window_sectors_q   <= count_shadow_q;
							window_to_device_q <= arm_push;
							window_armed_q     <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/dsnp_fifo.sv =====
// dsnp_fifo: short command queue between the front and back parts
// register array with read and write pointers; uses dsnp_pkg
module dsnp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dsnp_pkg::sync_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output dsnp_pkg::sync_cmd_t pop_cmd,
	output logic                empty
);
	import dsnp_pkg::*;

	sync_cmd_t             slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);

	assign full    = count_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/dsnp_back.sv =====
// dsnp_back: drains the queue, drops empty or out of range windows
// holds the sync command output register; uses dsnp_pkg
module dsnp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dsnp_pkg::cfg_t      cfg,
	input  logic                empty,
	input  dsnp_pkg::sync_cmd_t head_cmd,
	output logic                pop,
	output logic                sync_valid,
	input  logic                sync_stall,
	output dsnp_pkg::sync_cmd_t sync
);
	import dsnp_pkg::*;

	logic        out_valid_q;
	sync_cmd_t   out_cmd_q;
	logic [25:0] window_end;
	logic        in_range;

	assign window_end = {2'b00, head_cmd.sync_base}
		+ {9'd0, head_cmd.sync_sectors, {SECTOR_SHIFT{1'b0}}};
	assign in_range   = head_cmd.sync_sectors != 8'd0
		&& window_end <= {1'b0, cfg.ram_limit};
	assign pop        = !empty && (!out_valid_q || !sync_stall);
	assign sync_valid = out_valid_q;
	assign sync       = out_cmd_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_cmd_q <= head_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= in_range;
		end else if (!sync_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/dma_register_snoop_sync.sv =====
// dma_register_snoop_sync: top level of the dma register snoop block
// holds the apb configuration registers; uses dsnp_pkg, dsnp_front,
// dsnp_fifo and dsnp_back
//
// usage
//   access channel (access_valid, access_stall, access): one observed bus
//   access per transfer, accepted when valid is high and stall is low.
//   sync channel (sync_valid, sync_stall, sync): zero or one mirror sync
//   command per access, in access order.
//   apb port: snoop_enable, ram_limit, count_select_mask, direction_mask,
//   count_zero_mask at byte addresses 0, 4, 8, 12, 16; write only while idle.
// timing
//   one access per cycle while the queue is not full; a command reaches sync
//   through the queue and the output register: the front writes it into a
//   four-entry command queue at the accepting edge and the output register then
//   takes it from the queue head. when sync stalls, the output register holds
//   and the queue fills; access_stall rises only when the queue is full.
// reset
//   arst_n clears all shadows, the window, the queue and the output valid;
//   configuration returns to its reset values, snooping disabled.
module dma_register_snoop_sync (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          access_valid,
	output logic                          access_stall,
	input  dsnp_pkg::access_t             access,
	output logic                          sync_valid,
	input  logic                          sync_stall,
	output dsnp_pkg::sync_cmd_t           sync,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsnp_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import dsnp_pkg::*;

	cfg_t      cfg_q;
	logic      accept;
	logic      cmd_push;
	sync_cmd_t push_cmd;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	sync_cmd_t head_cmd;
	logic      wr_en;
	logic [2:0] reg_idx;

	assign pready       = 1'b1;
	assign wr_en        = psel && penable && pwrite && pready;
	assign reg_idx      = paddr[4:2];
	assign access_stall = q_full;
	assign accept       = access_valid && !access_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.snoop_enable      <= 1'b0;
			cfg_q.ram_limit         <= RAM_LIMIT_RESET;
			cfg_q.count_select_mask <= COUNT_SEL_RESET;
			cfg_q.direction_mask    <= DIRECTION_RESET;
			cfg_q.count_zero_mask   <= COUNT_ZERO_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				IDX_SNOOP_ENABLE: cfg_q.snoop_enable      <= pwdata[0];
				IDX_RAM_LIMIT:    cfg_q.ram_limit         <= pwdata[24:0];
				IDX_COUNT_SEL:    cfg_q.count_select_mask <= pwdata[15:0];
				IDX_DIRECTION:    cfg_q.direction_mask    <= pwdata[15:0];
				IDX_COUNT_ZERO:   cfg_q.count_zero_mask   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			IDX_SNOOP_ENABLE: prdata = {31'd0, cfg_q.snoop_enable};
			IDX_RAM_LIMIT:    prdata = {7'd0, cfg_q.ram_limit};
			IDX_COUNT_SEL:    prdata = {16'd0, cfg_q.count_select_mask};
			IDX_DIRECTION:    prdata = {16'd0, cfg_q.direction_mask};
			IDX_COUNT_ZERO:   prdata = {16'd0, cfg_q.count_zero_mask};
			default:          prdata = 32'd0;
		endcase
	end

	dsnp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.access   (access),
		.push     (cmd_push),
		.push_cmd (push_cmd)
	);

	dsnp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (head_cmd),
		.empty    (q_empty)
	);

	dsnp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.empty      (q_empty),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.sync_valid (sync_valid),
		.sync_stall (sync_stall),
		.sync       (sync)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_q.snoop_enable |-> !cmd_push)
		else $error("command generated while snooping is disabled");

	a_pull_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && push_cmd.sync_direction == DIR_PULL) |-> (access.operation == OP_READ))
		else $error("pull command not caused by a status read");

	a_nonzero_sectors: assert property (@(posedge clk) disable iff (!arst_n)
		sync_valid |-> (sync.sync_sectors != 8'd0))
		else $error("zero length command delivered");

endmodule
